>>> hdl/mtb_pkg.sv
// Shared types, codes and constants for the timer bank core.
// Used by mtb_ctrl, mtb_datapath and the top level; depends on nothing.
`default_nettype none

package mtb_pkg;

    // Default bank size and per-item expiry report limit
    localparam int TIMER_COUNT_DEF = 16;
    localparam int MAX_EVENTS      = 16;
    localparam int EVT_CNT_W       = $clog2(MAX_EVENTS + 1);

    localparam logic [31:0] NONE_LEFT      = 32'hFFFF_FFFF;
    localparam logic [31:0] RELOAD_CAP     = 32'hFFFF_FFFE;
    localparam logic [31:0] MAX_RELOAD_RST = 32'd65535;

    // Operation codes
    localparam logic [2:0] KIND_ALLOC  = 3'd0;
    localparam logic [2:0] KIND_FREE   = 3'd1;
    localparam logic [2:0] KIND_SET    = 3'd2;
    localparam logic [2:0] KIND_START  = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;
    localparam logic [2:0] KIND_ELAPSE = 3'd5;

    // Completion status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_PARAM = 2'd1;
    localparam logic [1:0] STAT_BAD_STATE = 2'd2;
    localparam logic [1:0] STAT_NO_FREE   = 2'd3;

    // Timer states
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    // Result kinds
    localparam logic EVT_EXPIRY = 1'b0;
    localparam logic EVT_DONE   = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] reload;
        logic [31:0] countdown;
        logic        rpt;
        logic        ntf;
    } entry_t;

    localparam entry_t ENTRY_RST = '{
        status:    ST_FREE,
        reload:    32'd0,
        countdown: NONE_LEFT,
        rpt:       1'b0,
        ntf:       1'b0
    };

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic chk_rd;
        logic chk_latch;
        logic walk_start;
        logic walk_run;
        logic set_second;
        logic fin;
        logic done_emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic need_second;
        logic second;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/mtb_ctrl.sv
// Sequencer for the timer bank: check read, one or two table walks, completion.
// Depends on mtb_pkg for the command and status structs.
`default_nettype none

module mtb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  mtb_pkg::dp_stat_t      stat,
    output mtb_pkg::ctrl_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHK_RD = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_WALK2  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Decode state into commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHK_RD;
                end
            end
            S_CHK_RD: begin
                cmd.chk_rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.chk_latch  = 1'b1;
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK: begin
                cmd.walk_run = 1'b1;
                if (stat.walk_done) begin
                    if (stat.need_second && !stat.second) begin
                        state_next = S_WALK2;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_WALK2: begin
                cmd.walk_start = 1'b1;
                cmd.set_second = 1'b1;
                state_next     = S_WALK;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                cmd.done_emit = 1'b1;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

>>> hdl/mtb_datapath.sv
// Datapath of the timer bank: item registers, timer table, walk pipeline,
// minimum search and result register. Depends on mtb_pkg.
`default_nettype none

module mtb_datapath #(
    parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  mtb_pkg::ctrl_cmd_t      cmd,
    output mtb_pkg::dp_stat_t       stat,
    input  wire logic [2:0]         s_kind,
    input  wire logic [7:0]         s_timer_index,
    input  wire logic [31:0]        s_reload_ms,
    input  wire logic               s_repeat_req,
    input  wire logic               s_notify,
    input  wire logic [31:0]        s_elapsed_ms,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_event_type,
    output logic [7:0]              m_result_index,
    output logic [1:0]              m_status,
    output logic [1:0]              m_entry_state,
    output logic [31:0]             m_next_deadline_ms,
    output logic [31:0]             m_hw_reload_ms,
    output logic                    m_tick_run,
    output logic                    m_last
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W = $clog2(TIMER_COUNT + 1);
    localparam int EW    = mtb_pkg::EVT_CNT_W;

    // Item and configuration registers
    logic [2:0]  kind_reg;
    logic [7:0]  idx_reg;
    logic [31:0] reload_reg;
    logic        rpt_reg;
    logic        ntf_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] max_reload_reg;

    // Per-item control
    logic [1:0]  status_reg;
    logic        found_reg;
    logic        second_reg;
    logic [EW-1:0] evt_cnt_reg;
    logic [7:0]  res_idx_reg;
    logic [1:0]  est_reg;
    logic [31:0] next_reg;

    // Timer table
    mtb_pkg::entry_t mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] valid_reg;
    mtb_pkg::entry_t rd_entry_reg;
    logic        rd_vld_reg;

    // Walk pipeline
    logic [CNT_W-1:0] ptr_reg;
    logic             stg_vld_reg;
    logic [IDX_W-1:0] stg_addr_reg;
    logic             mn_vld_reg;
    logic             mn_run_reg;
    logic [31:0]      mn_cd_reg;
    logic [31:0]      min_reg;

    logic             m_valid_reg;

    logic             idx_ok;
    logic [IDX_W-1:0] idx_addr;
    mtb_pkg::entry_t  cur_entry;
    mtb_pkg::entry_t  new_entry;
    logic [1:0]       chk_status;
    logic             op_ok;
    logic             is_adv_kind;
    logic             adv_en;
    logic             apply_en;
    logic             at_idx;
    logic [31:0]      step;
    logic [31:0]      dec;
    logic [31:0]      reload_m1;
    logic             expire;
    logic             alloc_here;
    logic             emit;
    logic             out_free;
    logic             adv;
    logic             fire;
    logic             ptr_lt_n;
    logic             walk_issue;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      hw_reload;

    assign idx_ok   = ({1'b0, idx_reg} < 9'(TIMER_COUNT));
    assign idx_addr = idx_reg[IDX_W-1:0];

    // Entry never written reads as its reset value
    assign cur_entry = rd_vld_reg ? rd_entry_reg : mtb_pkg::ENTRY_RST;

    // Check the addressed timer before any walk
    always_comb begin
        chk_status = mtb_pkg::STAT_OK;
        case (kind_reg)
            mtb_pkg::KIND_ALLOC: begin
                chk_status = mtb_pkg::STAT_NO_FREE;
            end
            mtb_pkg::KIND_FREE, mtb_pkg::KIND_START: begin
                if (!idx_ok) begin
                    chk_status = mtb_pkg::STAT_BAD_PARAM;
                end else if (cur_entry.status != mtb_pkg::ST_STOPPED) begin
                    chk_status = mtb_pkg::STAT_BAD_STATE;
                end
            end
            mtb_pkg::KIND_SET: begin
                if (!idx_ok || (reload_reg <= 32'd1) || (reload_reg > max_reload_reg)) begin
                    chk_status = mtb_pkg::STAT_BAD_PARAM;
                end else if (cur_entry.status != mtb_pkg::ST_STOPPED) begin
                    chk_status = mtb_pkg::STAT_BAD_STATE;
                end
            end
            mtb_pkg::KIND_STOP: begin
                if (!idx_ok) begin
                    chk_status = mtb_pkg::STAT_BAD_PARAM;
                end else if (cur_entry.status != mtb_pkg::ST_RUNNING) begin
                    chk_status = mtb_pkg::STAT_BAD_STATE;
                end
            end
            default: begin
                chk_status = mtb_pkg::STAT_OK;
            end
        endcase
    end

    // Walk mode for this pass
    assign op_ok       = (status_reg == mtb_pkg::STAT_OK);
    assign is_adv_kind = (kind_reg inside {mtb_pkg::KIND_START, mtb_pkg::KIND_STOP})
                         || (kind_reg >= mtb_pkg::KIND_ELAPSE);
    assign adv_en      = op_ok && is_adv_kind;
    assign apply_en    = op_ok && ((kind_reg inside {mtb_pkg::KIND_FREE, mtb_pkg::KIND_SET,
                                                     mtb_pkg::KIND_STOP})
                                   || ((kind_reg == mtb_pkg::KIND_START) && !second_reg));
    assign at_idx      = idx_ok && (stg_addr_reg == idx_addr);
    assign step        = second_reg ? 32'd0 : elapsed_reg;
    assign dec         = cur_entry.countdown - step;
    assign reload_m1   = cur_entry.reload - 32'd1;

    // Update one timer: the addressed operation, a countdown step, or allocation
    always_comb begin
        new_entry  = cur_entry;
        expire     = 1'b0;
        alloc_here = 1'b0;
        if (apply_en && at_idx) begin
            case (kind_reg)
                mtb_pkg::KIND_FREE: begin
                    new_entry.status = mtb_pkg::ST_FREE;
                end
                mtb_pkg::KIND_SET: begin
                    new_entry.reload = reload_reg;
                    new_entry.rpt    = rpt_reg;
                    new_entry.ntf    = ntf_reg;
                end
                mtb_pkg::KIND_START: begin
                    new_entry.countdown = reload_m1;
                    new_entry.status    = mtb_pkg::ST_RUNNING;
                end
                mtb_pkg::KIND_STOP: begin
                    new_entry.status    = mtb_pkg::ST_STOPPED;
                    new_entry.countdown = mtb_pkg::NONE_LEFT;
                    new_entry.rpt       = 1'b0;
                end
                default: begin
                    new_entry = cur_entry;
                end
            endcase
        end else if (adv_en && (cur_entry.status == mtb_pkg::ST_RUNNING)
                     && !((cur_entry.countdown == 32'd0) && (step != 32'd0))) begin
            if (dec == 32'd0) begin
                expire = 1'b1;
                if (cur_entry.rpt) begin
                    new_entry.countdown = reload_m1;
                end else begin
                    new_entry.status    = mtb_pkg::ST_STOPPED;
                    new_entry.countdown = mtb_pkg::NONE_LEFT;
                    new_entry.rpt       = 1'b0;
                end
            end else begin
                new_entry.countdown = dec;
            end
        end else if ((kind_reg == mtb_pkg::KIND_ALLOC) && !found_reg
                     && (cur_entry.status == mtb_pkg::ST_FREE)) begin
            alloc_here       = 1'b1;
            new_entry.status = mtb_pkg::ST_STOPPED;
        end
    end

    // Stall the walk while an expiry report cannot enter the result register
    assign emit       = expire && cur_entry.ntf && (evt_cnt_reg < EW'(mtb_pkg::MAX_EVENTS));
    assign out_free   = !m_valid_reg || m_ready;
    assign adv        = !(stg_vld_reg && emit && !out_free);
    assign fire       = cmd.walk_run && stg_vld_reg && adv;
    assign ptr_lt_n   = (ptr_reg < CNT_W'(TIMER_COUNT));
    assign walk_issue = cmd.walk_run && adv && ptr_lt_n;
    assign rd_en      = cmd.chk_rd || walk_issue;
    assign rd_addr    = cmd.chk_rd ? idx_addr : ptr_reg[IDX_W-1:0];

    // Timer table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (fire) begin
            mem[stg_addr_reg] <= new_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
            rd_vld_reg   <= valid_reg[rd_addr];
        end
    end

    // Mark entries written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (fire) begin
            valid_reg[stg_addr_reg] <= 1'b1;
        end
    end

    // Capture item, hold the stage address and the updated entry for the minimum search
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg    <= s_kind;
            idx_reg     <= s_timer_index;
            reload_reg  <= s_reload_ms;
            rpt_reg     <= s_repeat_req;
            ntf_reg     <= s_notify;
            elapsed_reg <= s_elapsed_ms;
        end
        if (walk_issue) begin
            stg_addr_reg <= ptr_reg[IDX_W-1:0];
        end
        if (fire) begin
            mn_cd_reg  <= new_entry.countdown;
            mn_run_reg <= (new_entry.status == mtb_pkg::ST_RUNNING);
        end
    end

    // Walk pointer and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            stg_vld_reg <= 1'b0;
            mn_vld_reg  <= 1'b0;
        end else if (cmd.walk_start) begin
            ptr_reg     <= '0;
            stg_vld_reg <= 1'b0;
            mn_vld_reg  <= 1'b0;
        end else begin
            mn_vld_reg <= fire;
            if (cmd.walk_run && adv) begin
                stg_vld_reg <= ptr_lt_n;
                if (ptr_lt_n) begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
            end
        end
    end

    // Track the least running countdown over the pass
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            min_reg <= mtb_pkg::NONE_LEFT;
        end else if (mn_vld_reg && mn_run_reg && (mn_cd_reg < min_reg)) begin
            min_reg <= mn_cd_reg;
        end
        if (cmd.fin) begin
            next_reg <= (min_reg == mtb_pkg::NONE_LEFT) ? 32'd0 : min_reg;
        end
    end

    // Per-item status, allocation and reported state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= mtb_pkg::STAT_OK;
            found_reg   <= 1'b0;
            second_reg  <= 1'b0;
            evt_cnt_reg <= '0;
            res_idx_reg <= '0;
            est_reg     <= mtb_pkg::ST_FREE;
        end else if (cmd.chk_latch) begin
            status_reg  <= chk_status;
            found_reg   <= 1'b0;
            second_reg  <= 1'b0;
            evt_cnt_reg <= '0;
            res_idx_reg <= (kind_reg == mtb_pkg::KIND_ALLOC) ? 8'd0 : idx_reg;
            est_reg     <= mtb_pkg::ST_FREE;
        end else begin
            if (cmd.set_second) begin
                second_reg <= 1'b1;
            end
            if (fire && emit) begin
                evt_cnt_reg <= evt_cnt_reg + EW'(1);
            end
            if (fire && alloc_here) begin
                found_reg   <= 1'b1;
                status_reg  <= mtb_pkg::STAT_OK;
                res_idx_reg <= 8'(stg_addr_reg);
                est_reg     <= new_entry.status;
            end else if (fire && (kind_reg != mtb_pkg::KIND_ALLOC) && at_idx) begin
                est_reg <= new_entry.status;
            end
        end
    end

    // Configuration register, saturated to the reload cap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reload_reg <= mtb_pkg::MAX_RELOAD_RST;
        end else if (cfg_valid) begin
            max_reload_reg <= (cfg_data > mtb_pkg::RELOAD_CAP) ? mtb_pkg::RELOAD_CAP : cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign hw_reload = (next_reg > max_reload_reg) ? max_reload_reg : next_reg;

    // Result register: expiry reports during the walk, completion at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((fire && emit) || (cmd.done_emit && out_free)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_event_type       <= mtb_pkg::EVT_EXPIRY;
            m_result_index     <= 8'(stg_addr_reg);
            m_status           <= mtb_pkg::STAT_OK;
            m_entry_state      <= new_entry.status;
            m_next_deadline_ms <= 32'd0;
            m_hw_reload_ms     <= 32'd0;
            m_tick_run         <= 1'b0;
            m_last             <= 1'b0;
        end else if (cmd.done_emit && out_free) begin
            m_event_type       <= mtb_pkg::EVT_DONE;
            m_result_index     <= res_idx_reg;
            m_status           <= status_reg;
            m_entry_state      <= est_reg;
            m_next_deadline_ms <= next_reg;
            m_hw_reload_ms     <= hw_reload;
            m_tick_run         <= (next_reg != 32'd0);
            m_last             <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

    assign stat.walk_done   = (ptr_reg == CNT_W'(TIMER_COUNT)) && !stg_vld_reg && !mn_vld_reg;
    assign stat.need_second = (kind_reg == mtb_pkg::KIND_START) && op_ok;
    assign stat.second      = second_reg;
    assign stat.out_free    = out_free;

endmodule

`default_nettype wire

>>> hdl/multi_timer_bank_next_deadline_core.sv
// Top level of the timer bank core: controller plus datapath.
// Depends on mtb_pkg, mtb_ctrl and mtb_datapath.
`default_nettype none

// One operation is taken at a time. Each item does a check read of the
// addressed timer, then walks the timer table one entry per cycle through
// its single read port, stalling while an expiry report waits on m_ready
// and reporting expiries on the way, and ends with one completion result
// marked by m_last. A successful start walks the table twice. Timers read
// as freshly reset until first written, so no clearing pass follows reset.
// max_reload_ms is to be written through the cfg port only while the core
// is idle; the core itself does not enforce this. Values above 0xFFFFFFFE
// saturate.
module multi_timer_bank_next_deadline_core #(
    parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_kind,
    input  wire logic [7:0]  s_timer_index,
    input  wire logic [31:0] s_reload_ms,
    input  wire logic        s_repeat_req,
    input  wire logic        s_notify,
    input  wire logic [31:0] s_elapsed_ms,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_event_type,
    output logic [7:0]       m_result_index,
    output logic [1:0]       m_status,
    output logic [1:0]       m_entry_state,
    output logic [31:0]      m_next_deadline_ms,
    output logic [31:0]      m_hw_reload_ms,
    output logic             m_tick_run,
    output logic             m_last
);

    mtb_pkg::ctrl_cmd_t cmd;
    mtb_pkg::dp_stat_t  stat;

    mtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mtb_datapath #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_kind             (s_kind),
        .s_timer_index      (s_timer_index),
        .s_reload_ms        (s_reload_ms),
        .s_repeat_req       (s_repeat_req),
        .s_notify           (s_notify),
        .s_elapsed_ms       (s_elapsed_ms),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_type       (m_event_type),
        .m_result_index     (m_result_index),
        .m_status           (m_status),
        .m_entry_state      (m_entry_state),
        .m_next_deadline_ms (m_next_deadline_ms),
        .m_hw_reload_ms     (m_hw_reload_ms),
        .m_tick_run         (m_tick_run),
        .m_last             (m_last)
    );

    // An accepted item blocks the input until its completion
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // Expiry reports succeed and never close an item
    a_expiry_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_type == mtb_pkg::EVT_EXPIRY))
            |-> (!m_last && (m_status == mtb_pkg::STAT_OK) && !m_tick_run))
        else $error("malformed expiry report");

    // Completion: tick source runs exactly when a deadline exists, capped reload
    a_done_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_type == mtb_pkg::EVT_DONE))
            |-> (m_last && (m_tick_run == (m_next_deadline_ms != 32'd0))
                 && (m_hw_reload_ms <= m_next_deadline_ms)))
        else $error("inconsistent completion result");

endmodule

`default_nettype wire
